>>> src/tmcw_pkg.sv
// shared constants and types for the text mode console writer
// screen geometry, cell codes, item kinds and sequencer states
// no dependencies
package tmcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CHAR_W + COLOR_W;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    localparam int SCROLL_LEN    = CELLS - COLUMNS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_BLANK,
        S_CLEAR,
        S_READ,
        S_DONE
    } state_t;

endpackage

>>> src/text_mode_console_writer_top.sv
// text mode console writer: screen store, cursor and the sequencer that drives them
// depends on tmcw_pkg
//
// usage
//   command channel: an item is taken when start is high and busy is low.
//   kind selects write character, clear screen or read one cell.
//   result: one beat per item, shown for exactly one cycle while done is high;
//   the receiver cannot stall, so it must take the beat in that cycle.
//   config: text_color is written when cfg_valid and cfg_ready are high;
//   cfg_ready is always high, write it only while the block is idle.
// sequence, from the accepting edge to the done cycle
//   plain character: one store write (S_PUT); newline without scroll: no write
//   read: the cell is read and registered (S_READ); unused kind: straight to done
//   clear screen: every cell gets a space in text_color, one store write a cycle
//   scroll: copies rows up (S_SCROLL), then blanks the last row (S_BLANK);
//   the copy uses one read and one write port of the store each cycle
//   the next item is taken the cycle after done.
// reset
//   cursor goes to 0,0 and text_color to 7; then a clearing pass writes zero
//   into every cell, with busy high throughout.
module text_mode_console_writer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       kind,
    input  logic [tmcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tmcw_pkg::ROW_W-1:0]       read_row,
    input  logic [tmcw_pkg::COL_W-1:0]       read_col,
    output logic                             done,
    output logic [tmcw_pkg::CHAR_W-1:0]      cell_char,
    output logic [tmcw_pkg::COLOR_W-1:0]     cell_color,
    output logic [tmcw_pkg::ROW_W-1:0]       cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]       cursor_col,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmcw_pkg::COLOR_W-1:0]     cfg_data
);
    import tmcw_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ROW_W-1:0]     cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]     cursor_col_reg, cursor_col_next;
    logic [COLOR_W-1:0]   text_color_reg;
    logic [CHAR_W-1:0]    ch_reg, ch_next;
    logic [1:0]           kind_reg, kind_next;
    logic                 in_range_reg, in_range_next;
    logic                 pend_put_reg, pend_put_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;

    logic [CELL_W-1:0]    screen_mem [CELLS];
    logic [CELL_W-1:0]    rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [CELL_W-1:0]    mem_wdata;

    logic                 accept;
    logic                 req_in_range;
    logic [ADDR_W-1:0]    req_addr;
    logic [ADDR_W-1:0]    cursor_addr;
    logic                 on_last_row;

    assign accept       = start && !busy;
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign cfg_ready    = 1'b1;
    assign cell_char    = out_char_reg;
    assign cell_color   = out_color_reg;
    assign cursor_row   = cursor_row_reg;
    assign cursor_col   = cursor_col_reg;

    assign req_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
    assign req_addr     = ADDR_W'(32'(read_row) * COLUMNS + 32'(read_col));
    assign cursor_addr  = ADDR_W'(32'(cursor_row_reg) * COLUMNS + 32'(cursor_col_reg));
    assign on_last_row  = (32'(cursor_row_reg) >= ROWS - 1);

    // screen store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= screen_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            text_color_reg <= COLOR_RESET;
            pend_put_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            pend_put_reg   <= pend_put_next;
            if (cfg_valid && cfg_ready)
            begin
                text_color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        kind_reg      <= kind_next;
        in_range_reg  <= in_range_next;
        out_char_reg  <= out_char_next;
        out_color_reg <= out_color_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        pend_put_next   = pend_put_reg;
        ch_next         = ch_reg;
        kind_next       = kind_reg;
        in_range_next   = in_range_reg;
        out_char_next   = out_char_reg;
        out_color_next  = out_color_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (32'(cnt_reg) == CELLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                mem_raddr = req_in_range ? req_addr : '0;
                if (accept)
                begin
                    ch_next        = char_code;
                    kind_next      = kind;
                    in_range_next  = req_in_range;
                    out_char_next  = '0;
                    out_color_next = '0;
                    cnt_next       = '0;
                    pend_put_next  = 1'b0;
                    state_next     = S_DONE;
                    case (kind)
                        KIND_WRITE:
                        begin
                            if (char_code == NEWLINE_CODE)
                            begin
                                cursor_col_next = '0;
                                if (on_last_row)
                                begin
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    cursor_row_next = cursor_row_reg + 1'b1;
                                end
                            end
                            else if (32'(cursor_col_reg) >= COLUMNS)
                            begin
                                cursor_col_next = '0;
                                if (on_last_row)
                                begin
                                    pend_put_next = 1'b1;
                                    state_next    = S_SCROLL;
                                end
                                else
                                begin
                                    cursor_row_next = cursor_row_reg + 1'b1;
                                    state_next      = S_PUT;
                                end
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        KIND_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = cursor_addr;
                mem_wdata       = {text_color_reg, ch_reg};
                cursor_col_next = cursor_col_reg + 1'b1;
                pend_put_next   = 1'b0;
                state_next      = S_DONE;
            end

            // copy row r+1 into row r, read one ahead of the write
            S_SCROLL:
            begin
                if (32'(cnt_reg) < SCROLL_LEN)
                begin
                    mem_raddr = ADDR_W'(32'(cnt_reg) + COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(32'(cnt_reg) - 1);
                    mem_wdata = rdata_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == SCROLL_LEN)
                begin
                    cnt_next   = '0;
                    state_next = S_BLANK;
                end
            end

            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(LAST_ROW_BASE + 32'(cnt_reg));
                mem_wdata = {text_color_reg, SPACE_CODE};
                cnt_next  = cnt_reg + 1'b1;
                if (32'(cnt_reg) == COLUMNS - 1)
                begin
                    cnt_next   = '0;
                    state_next = pend_put_reg ? S_PUT : S_DONE;
                end
            end

            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = {text_color_reg, SPACE_CODE};
                cnt_next  = cnt_reg + 1'b1;
                if (32'(cnt_reg) == CELLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                if (in_range_reg)
                begin
                    out_char_next  = rdata_reg[CHAR_W-1:0];
                    out_color_next = rdata_reg[CELL_W-1:CHAR_W];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after taking an item");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_row_reg) < ROWS)
        else $error("cursor row past last row");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_col_reg) <= COLUMNS)
        else $error("cursor column past row end");

    a_zero_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind_reg != KIND_READ) |-> (cell_char == '0 && cell_color == '0))
        else $error("cell fields nonzero for a non-read item");

endmodule

>>> test/tb_text_mode_console_writer_top.sv
// testbench for text_mode_console_writer_top: directed and random command streams
// checked beat by beat against a screen and cursor predictor kept in the bench
// depends on tmcw_pkg and the block under test
module tb_text_mode_console_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES       = 5;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } cell_beat_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          kind;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_W-1:0]    read_row;
    logic [COL_W-1:0]    read_col;
    logic                done;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOR_W-1:0]  cell_color;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COLOR_W-1:0]  cfg_data;

    logic [CHAR_W-1:0]   shadow_char [CELLS];
    logic [COLOR_W-1:0]  shadow_color [CELLS];
    int                  cur_row;
    int                  cur_col;
    logic [COLOR_W-1:0]  color_reg;
    cell_beat_t          pending_beats [$];
    int                  mismatches;
    int                  cycles;
    int                  items_sent;
    bit                  idle_gaps;

    text_mode_console_writer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .done       (done),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void blank_row(int r);
        for (int c = 0; c < COLUMNS; c++)
        begin
            shadow_char[r * COLUMNS + c]  = SPACE_CODE;
            shadow_color[r * COLUMNS + c] = color_reg;
        end
    endfunction

    function automatic void advance_line();
        cur_col = 0;
        if (cur_row < ROWS - 1)
        begin
            cur_row++;
        end
        else
        begin
            for (int i = 0; i < SCROLL_LEN; i++)
            begin
                shadow_char[i]  = shadow_char[i + COLUMNS];
                shadow_color[i] = shadow_color[i + COLUMNS];
            end
            blank_row(ROWS - 1);
        end
    endfunction

    function automatic void store_byte(logic [CHAR_W-1:0] ch);
        int idx;
        if (ch == NEWLINE_CODE)
        begin
            advance_line();
            return;
        end
        if (cur_col >= COLUMNS)
        begin
            advance_line();
        end
        idx = cur_row * COLUMNS + cur_col;
        if (idx < CELLS)
        begin
            shadow_char[idx]  = ch;
            shadow_color[idx] = color_reg;
        end
        cur_col++;
    endfunction

    function automatic cell_beat_t console_step(logic [1:0] k, logic [CHAR_W-1:0] ch,
                                                logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        cell_beat_t beat;
        beat.ch    = '0;
        beat.color = '0;
        if (k == KIND_WRITE)
        begin
            store_byte(ch);
        end
        else if (k == KIND_CLEAR)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                blank_row(r);
            end
        end
        else if (k == KIND_READ)
        begin
            if (int'(rr) < ROWS && int'(rc) < COLUMNS)
            begin
                beat.ch    = shadow_char[int'(rr) * COLUMNS + int'(rc)];
                beat.color = shadow_color[int'(rr) * COLUMNS + int'(rc)];
            end
        end
        beat.row = cur_row[ROW_W-1:0];
        beat.col = cur_col[COL_W-1:0];
        return beat;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        int gap;
        gap = idle_gaps ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        kind      = k;
        char_code = ch;
        read_row  = rr;
        read_col  = rc;
        do
            @(posedge clk);
        while (busy);
        pending_beats.push_back(console_step(k, ch, rr, rc));
        items_sent++;
    endtask

    task automatic send_write(input logic [CHAR_W-1:0] ch);
        send_item(KIND_WRITE, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input int rr, input int rc);
        send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), ROW_W'(rr), COL_W'(rc));
    endtask

    task automatic send_clear();
        send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_text_color(input logic [COLOR_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        color_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = COLOR_W'($urandom_range(0, 255));
    endtask

    task automatic test_after_reset();
        send_read(0, 0);
        send_read(ROWS - 1, COLUMNS - 1);
        send_read(12, 40);
        send_item(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    task automatic test_write_extremes();
        send_write(8'h00);
        send_write(8'hFF);
        send_write(8'h41);
        send_write(NEWLINE_CODE);
        send_write(SPACE_CODE);
        send_read(0, 0);
        send_read(0, 1);
        send_read(0, 2);
        send_read(1, 0);
        send_read(1, 1);
    endtask

    task automatic test_read_out_of_range();
        send_read(ROWS, 0);
        send_read(0, COLUMNS);
        send_read(31, 127);
        send_read(ROWS - 1, COLUMNS);
        send_read(ROWS, COLUMNS - 1);
    endtask

    task automatic test_clear_screen();
        set_text_color(8'hA5);
        send_clear();
        send_read(0, 0);
        send_read(ROWS - 1, COLUMNS - 1);
        send_read(1, 0);
    endtask

    // fill whole rows to hit the wrap, then walk to the last row and scroll
    task automatic test_row_wrap_and_scroll();
        logic [CHAR_W-1:0] ch;
        int                base_row;
        idle_gaps = 1'b1;
        send_write(NEWLINE_CODE);
        base_row = cur_row;
        for (int i = 0; i <= COLUMNS; i++)
        begin
            ch = CHAR_W'($urandom_range(0, 255));
            send_write(ch == NEWLINE_CODE ? 8'hFF : ch);
        end
        send_read(base_row, COLUMNS - 1);
        send_read(base_row + 1, 0);
        send_read(base_row, 0);
        while (cur_row < ROWS - 1)
            send_write(NEWLINE_CODE);
        send_write(8'h5A);
        send_write(NEWLINE_CODE);
        send_write(NEWLINE_CODE);
        send_read(ROWS - 3, 0);
        send_read(ROWS - 2, 0);
        send_read(ROWS - 1, 0);
        for (int i = 0; i <= COLUMNS; i++)
        begin
            ch = CHAR_W'($urandom_range(0, 255));
            send_write(ch == NEWLINE_CODE ? 8'h00 : ch);
        end
        send_read(ROWS - 2, COLUMNS - 1);
        send_read(ROWS - 1, 0);
        send_read(ROWS - 1, 1);
    endtask

    task automatic test_random_traffic();
        logic [COLOR_W-1:0] phase_color [PHASES];
        int                 target;
        int                 pick;
        int                 n;
        int                 r;
        phase_color[0] = 8'h00;
        phase_color[1] = 8'hFF;
        phase_color[2] = COLOR_W'($urandom_range(0, 255));
        phase_color[3] = 8'h1E;
        phase_color[4] = COLOR_RESET;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_text_color(phase_color[phase]);
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                idle_gaps = ($urandom_range(0, 9) < 7);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    n = $urandom_range(1, 95);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            r = cur_row - int'($urandom_range(0, 1));
                            send_read(r < 0 ? 0 : r, $urandom_range(0, COLUMNS + 1));
                        end
                        else if ($urandom_range(0, 29) == 0)
                            send_write(NEWLINE_CODE);
                        else
                            send_write(CHAR_W'($urandom_range(0, 255)));
                    end
                end
                else if (pick < 70)
                begin
                    n = $urandom_range(1, 16);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send_read($urandom_range(0, 31), $urandom_range(0, 127));
                        else
                            send_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
                    end
                end
                else if (pick < 80)
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_write(NEWLINE_CODE);
                end
                else if (pick < 82)
                    send_clear();
                else if (pick < 95)
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_item(KIND_UNUSED, CHAR_W'($urandom_range(0, 255)),
                                  ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
                end
                else
                    drain_results();
            end
        end
    endtask

    always @(posedge clk)
    begin : check_beat
        cell_beat_t want;
        if (rst_n && done)
        begin
            if (pending_beats.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected beat: char %0h color %0h row %0d col %0d",
                             cell_char, cell_color, cursor_row, cursor_col);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (cell_char !== want.ch || cell_color !== want.color ||
                    cursor_row !== want.row || cursor_col !== want.col)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("beat mismatch: expected char %0h color %0h row %0d col %0d",
                                 want.ch, want.color, want.row, want.col);
                        $display("  got char %0h color %0h row %0d col %0d",
                                 cell_char, cell_color, cursor_row, cursor_col);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_WRITE;
        char_code  = '0;
        read_row   = '0;
        read_col   = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        cycles     = 0;
        items_sent = 0;
        idle_gaps  = 1'b1;
        cur_row    = 0;
        cur_col    = 0;
        color_reg  = COLOR_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_char[i]  = '0;
            shadow_color[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_write_extremes();
        test_read_out_of_range();
        test_clear_screen();
        test_row_wrap_and_scroll();
        test_random_traffic();

        @(negedge clk);
        start = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
